// ----- hw/rtl/ssd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Segment distance package
// Shared widths, constants and transfer types of the segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int COORD_BITS          = 20;
    localparam int DEF_PARAM_FRAC_BITS = 16;
    localparam int DEF_DIST_FRAC_BITS  = 8;

    localparam int DIST_W    = 29;
    localparam int TOL_W     = 16;
    localparam int PAR_SHIFT = 32;
    localparam int MUL_LAT   = 4;
    localparam int MUL_CHUNK = 32;

    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_start_z;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] a_end_z;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_start_z;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
        logic signed [COORD_BITS-1:0] b_end_z;
    } t_seg_pair;

    typedef struct packed {
        logic [DIST_W-1:0] dist_q8;
        logic              degenerate;
    } t_seg_dist;

endpackage
`default_nettype wire

// ----- hw/rtl/segment_segment_distance.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Segment to segment distance
// Closest point distance between two 3D segments, fully pipelined.
//
//   Channel   Signals                                  Direction
//   input     i_in_valid, o_in_ready, i_in_data       pair of segments in
//   output    o_out_valid, i_out_ready, o_out_data    distance and flag out
//   config    i_cfg_wr_en, i_cfg_wr_data              parallel tolerance
//
// One transfer is taken per cycle while the output is not stalled. The
// three bit-serial divider pipelines and the square root pipeline dominate
// the pipeline depth.
// Reset clears the valid bits and loads the tolerance with one.
// A stalled output holds every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_segment_distance
    import ssd_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS,
    parameter int DIST_FRAC_BITS  = DEF_DIST_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_seg_pair        i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_seg_dist        o_out_data,
    input  logic             i_cfg_wr_en,
    input  logic [TOL_W-1:0] i_cfg_wr_data
);

    localparam int F    = PARAM_FRAC_BITS;
    localparam int DF   = DIST_FRAC_BITS;
    localparam int DW   = COORD_BITS + 1;
    localparam int PRW  = 2 * DW;
    localparam int PW   = 2 * DW + 2;
    localparam int MW   = 2 * PW;
    localparam int XW   = 2 * PW + 1;
    localparam int TW   = TOL_W + 1 + MW;
    localparam int CPW  = XW + PAR_SHIFT;
    localparam int TBW  = F + 2 + PW;
    localparam int SNW  = PW + F + 3;
    localparam int CPRW = F + 2 + DW;
    localparam int CCW  = DW + F + 3;
    localparam int SQW  = 2 * CCW;
    localparam int QW   = SQW + 2;
    localparam int K    = 2 * DF - 2 * F;
    localparam int KL   = (K > 0) ? K : 0;
    localparam int KR   = (K < 0) ? -K : 0;
    localparam int RW   = QW + KL;
    localparam int RB   = (RW + 1) / 2;
    localparam int SMW  = (RB > DIST_W) ? RB : DIST_W;
    localparam int LM   = MUL_LAT;
    localparam int DL   = F + 1;

    localparam int P_DIFF = 1;
    localparam int P_DOT  = 3;
    localparam int T1     = P_DOT + LM;
    localparam int T2     = T1 + LM;
    localparam int T3     = T2 + 1 + DL;
    localparam int P_SN   = T3 + LM + 1;
    localparam int T5     = P_SN + DL;
    localparam int P_TN   = T5 + LM + 1;
    localparam int T7     = P_TN + DL;
    localparam int P_SUM  = T7 + 2 + LM + 1;
    localparam int P_ROOT = P_SUM + RB;
    localparam int LAT    = P_ROOT + 1;

    logic                  w_en;
    logic [LAT:1]          r_vld;
    logic [TOL_W-1:0]      r_parallel_tol;

    logic signed [COORD_BITS-1:0] w_as [3];
    logic signed [COORD_BITS-1:0] w_ae [3];
    logic signed [COORD_BITS-1:0] w_bs [3];
    logic signed [COORD_BITS-1:0] w_be [3];

    logic signed [DW-1:0]  r_d1 [3];
    logic signed [DW-1:0]  r_d2 [3];
    logic signed [DW-1:0]  r_w  [3];
    logic signed [PRW-1:0] r_paa [3];
    logic signed [PRW-1:0] r_pab [3];
    logic signed [PRW-1:0] r_pbb [3];
    logic signed [PRW-1:0] r_pad [3];
    logic signed [PRW-1:0] r_pbd [3];
    logic signed [PW-1:0]  r_a;
    logic signed [PW-1:0]  r_b;
    logic signed [PW-1:0]  r_c;
    logic signed [PW-1:0]  r_d;
    logic signed [PW-1:0]  r_e;

    logic signed [MW-1:0]  w_ac;
    logic signed [MW-1:0]  w_bb;
    logic signed [MW-1:0]  w_ae_p;
    logic signed [MW-1:0]  w_bd_p;
    logic signed [XW-1:0]  r_det;
    logic signed [XW-1:0]  r_n1;
    logic signed [TW-1:0]  w_tolac;
    logic signed [TOL_W:0] w_tol_s;
    logic [2*XW-1:0]       w_dn_q;
    logic signed [XW-1:0]  w_det2;
    logic signed [XW-1:0]  w_n12;
    logic [2*PW-1:0]       w_ec2_q;
    logic signed [PW-1:0]  w_e2;
    logic signed [PW-1:0]  w_c2;
    logic                  w_par;
    logic signed [XW-1:0]  r_num1;
    logic signed [XW-1:0]  r_den1;

    logic [F:0]            w_t1;
    logic signed [F+1:0]   w_t1s;
    logic [PW-1:0]         w_b3_q;
    logic signed [TBW-1:0] w_tb;
    logic [2*PW-1:0]       w_ad4_q;
    logic signed [PW-1:0]  w_a4;
    logic signed [PW-1:0]  w_d4;
    logic signed [SNW-1:0] r_sn;
    logic signed [SNW-1:0] r_sd;

    logic [F:0]            w_s;
    logic signed [F+1:0]   w_ss;
    logic [PW-1:0]         w_b5_q;
    logic signed [TBW-1:0] w_sb;
    logic [2*PW-1:0]       w_ec6_q;
    logic signed [PW-1:0]  w_e6;
    logic signed [PW-1:0]  w_c6;
    logic signed [SNW-1:0] r_tn;
    logic signed [SNW-1:0] r_td;

    logic [F:0]            w_t;
    logic [F:0]            w_s7;
    logic [6*DW-1:0]       w_dd_q;
    logic [3*DW-1:0]       w_ww_q;
    logic signed [CPRW-1:0] r_sd1 [3];
    logic signed [CPRW-1:0] r_td2 [3];
    logic signed [CCW-1:0] r_cc [3];
    logic signed [SQW-1:0] w_sq [3];
    logic [QW-1:0]         r_sum;
    logic [RW-1:0]         w_sh;
    logic [RB-1:0]         w_root;
    logic                  w_deg;
    logic                  w_deg_q;
    logic [DIST_W-1:0]     n_dist;
    t_seg_dist             r_out;

    assign w_en       = ~r_vld[LAT] | i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld          <= '0;
            r_parallel_tol <= TOL_RESET;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-1:1], i_in_valid};
            end
            if (i_cfg_wr_en) begin
                r_parallel_tol <= i_cfg_wr_data;
            end
        end
    end

    assign w_as[0] = i_in_data.a_start_x;
    assign w_as[1] = i_in_data.a_start_y;
    assign w_as[2] = i_in_data.a_start_z;
    assign w_ae[0] = i_in_data.a_end_x;
    assign w_ae[1] = i_in_data.a_end_y;
    assign w_ae[2] = i_in_data.a_end_z;
    assign w_bs[0] = i_in_data.b_start_x;
    assign w_bs[1] = i_in_data.b_start_y;
    assign w_bs[2] = i_in_data.b_start_z;
    assign w_be[0] = i_in_data.b_end_x;
    assign w_be[1] = i_in_data.b_end_y;
    assign w_be[2] = i_in_data.b_end_z;

    // Differences, dot product terms and dot product sums.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d1[i]  <= DW'(w_ae[i]) - DW'(w_as[i]);
                r_d2[i]  <= DW'(w_be[i]) - DW'(w_bs[i]);
                r_w[i]   <= DW'(w_as[i]) - DW'(w_bs[i]);
                r_paa[i] <= r_d1[i] * r_d1[i];
                r_pab[i] <= r_d1[i] * r_d2[i];
                r_pbb[i] <= r_d2[i] * r_d2[i];
                r_pad[i] <= r_d1[i] * r_w[i];
                r_pbd[i] <= r_d2[i] * r_w[i];
            end
            r_a <= PW'(r_paa[0]) + PW'(r_paa[1]) + PW'(r_paa[2]);
            r_b <= PW'(r_pab[0]) + PW'(r_pab[1]) + PW'(r_pab[2]);
            r_c <= PW'(r_pbb[0]) + PW'(r_pbb[1]) + PW'(r_pbb[2]);
            r_d <= PW'(r_pad[0]) + PW'(r_pad[1]) + PW'(r_pad[2]);
            r_e <= PW'(r_pbd[0]) + PW'(r_pbd[1]) + PW'(r_pbd[2]);
        end
    end

    assign w_deg = (r_a == '0) || (r_c == '0);

    ssd_mul #(.A_W(PW), .B_W(PW)) u_mul_ac (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_a), .i_b(r_c), .o_p(w_ac));
    ssd_mul #(.A_W(PW), .B_W(PW)) u_mul_bb (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b), .i_b(r_b), .o_p(w_bb));
    ssd_mul #(.A_W(PW), .B_W(PW)) u_mul_ae (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_a), .i_b(r_e), .o_p(w_ae_p));
    ssd_mul #(.A_W(PW), .B_W(PW)) u_mul_bd (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b), .i_b(r_d), .o_p(w_bd_p));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det <= XW'(w_ac) - XW'(w_bb);
            r_n1  <= XW'(w_ae_p) - XW'(w_bd_p);
        end
    end

    assign w_tol_s = {1'b0, r_parallel_tol};

    ssd_mul #(.A_W(TOL_W + 1), .B_W(MW)) u_mul_tol (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_tol_s), .i_b(w_ac), .o_p(w_tolac));

    ssd_dly #(.W(2 * XW), .N(LM - 1)) u_dly_dn (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_det, r_n1}), .o_q(w_dn_q));
    ssd_dly #(.W(2 * PW), .N(T2 - P_DOT)) u_dly_ec2 (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_e, r_c}), .o_q(w_ec2_q));

    assign w_det2 = w_dn_q[2*XW-1:XW];
    assign w_n12  = w_dn_q[XW-1:0];
    assign w_e2   = w_ec2_q[2*PW-1:PW];
    assign w_c2   = w_ec2_q[PW-1:0];

    // Near-parallel pairs fall back to the projection onto the second segment.
    assign w_par = (w_det2 == '0) ||
                   ((CPW'(w_det2) <<< PAR_SHIFT) < CPW'(w_tolac));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num1 <= w_par ? XW'(w_e2) : w_n12;
            r_den1 <= w_par ? XW'(w_c2) : w_det2;
        end
    end

    ssd_div #(.W(XW), .F(F)) u_div_t1 (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num1), .i_den(r_den1), .o_q(w_t1));

    assign w_t1s = {1'b0, w_t1};

    ssd_dly #(.W(PW), .N(T3 - P_DOT)) u_dly_b3 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_b), .o_q(w_b3_q));

    ssd_mul #(.A_W(F + 2), .B_W(PW)) u_mul_tb (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_t1s), .i_b(w_b3_q), .o_p(w_tb));

    ssd_dly #(.W(2 * PW), .N(T3 + LM - P_DOT)) u_dly_ad4 (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_a, r_d}), .o_q(w_ad4_q));

    assign w_a4 = w_ad4_q[2*PW-1:PW];
    assign w_d4 = w_ad4_q[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sn <= SNW'(w_tb) - (SNW'(w_d4) <<< F);
            r_sd <= SNW'(w_a4) <<< F;
        end
    end

    ssd_div #(.W(SNW), .F(F)) u_div_s (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_sn), .i_den(r_sd), .o_q(w_s));

    assign w_ss = {1'b0, w_s};

    ssd_dly #(.W(PW), .N(T5 - P_DOT)) u_dly_b5 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_b), .o_q(w_b5_q));

    ssd_mul #(.A_W(F + 2), .B_W(PW)) u_mul_sb (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_ss), .i_b(w_b5_q), .o_p(w_sb));

    ssd_dly #(.W(2 * PW), .N(T5 + LM - P_DOT)) u_dly_ec6 (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_e, r_c}), .o_q(w_ec6_q));

    assign w_e6 = w_ec6_q[2*PW-1:PW];
    assign w_c6 = w_ec6_q[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tn <= SNW'(w_sb) + (SNW'(w_e6) <<< F);
            r_td <= SNW'(w_c6) <<< F;
        end
    end

    ssd_div #(.W(SNW), .F(F)) u_div_t (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_tn), .i_den(r_td), .o_q(w_t));

    ssd_dly #(.W(F + 1), .N(T7 - T5)) u_dly_s7 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_s), .o_q(w_s7));
    ssd_dly #(.W(6 * DW), .N(T7 - P_DIFF)) u_dly_dd (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({r_d1[0], r_d1[1], r_d1[2], r_d2[0], r_d2[1], r_d2[2]}),
        .o_q(w_dd_q));
    ssd_dly #(.W(3 * DW), .N(T7 + 1 - P_DIFF)) u_dly_ww (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_w[0], r_w[1], r_w[2]}), .o_q(w_ww_q));

    // Closest point difference vector in parameter fraction units.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sd1[i] <= $signed({1'b0, w_s7}) *
                            $signed(w_dd_q[(5-i)*DW +: DW]);
                r_td2[i] <= $signed({1'b0, w_t}) *
                            $signed(w_dd_q[(2-i)*DW +: DW]);
                r_cc[i]  <= (CCW'($signed(w_ww_q[(2-i)*DW +: DW])) <<< F) +
                            CCW'(r_sd1[i]) - CCW'(r_td2[i]);
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_sq
        ssd_mul #(.A_W(CCW), .B_W(CCW)) u_mul_sq (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_cc[g]), .i_b(r_cc[g]), .o_p(w_sq[g]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= QW'(w_sq[0]) + QW'(w_sq[1]) + QW'(w_sq[2]);
        end
    end

    assign w_sh = (RW'(r_sum) << KL) >> KR;

    ssd_sqrt #(.RB(RB)) u_sqrt (
        .i_clk(i_clk), .i_en(w_en), .i_x((2*RB)'(w_sh)), .o_root(w_root));

    ssd_dly #(.W(1), .N(P_ROOT - P_DOT)) u_dly_deg (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_deg), .o_q(w_deg_q));

    assign n_dist = (SMW'(w_root) > SMW'(DIST_MAX)) ? DIST_MAX : DIST_W'(w_root);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.dist_q8    <= n_dist;
            r_out.degenerate <= w_deg_q;
        end
    end

    assign o_out_valid = r_vld[LAT];
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- hw/rtl/ssd_dly.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Delay line
// Carries side data alongside the pipeline for a fixed number of stages.
// ----------------------------------------------------------------------------
module ssd_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[N-1];

endmodule
`default_nettype wire

// ----- hw/rtl/ssd_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Sign and magnitude split, chunked partial products, summation, sign restore.
// ----------------------------------------------------------------------------
module ssd_mul
    import ssd_pkg::*;
#(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    localparam int NA  = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB  = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int AX  = NA * MUL_CHUNK;
    localparam int BX  = NB * MUL_CHUNK;
    localparam int SW  = AX + BX;
    localparam int P_W = A_W + B_W;

    logic [A_W-1:0]           w_abs_a;
    logic [B_W-1:0]           w_abs_b;
    logic [AX-1:0]            r_ma;
    logic [BX-1:0]            r_mb;
    logic [2*MUL_CHUNK-1:0]   r_pp [NA][NB];
    logic [SW-1:0]            n_sum;
    logic [SW-1:0]            r_sum;
    logic [P_W-1:0]           n_p;
    logic                     r_neg1;
    logic                     r_neg2;
    logic                     r_neg3;
    logic signed [P_W-1:0]    r_p;

    assign w_abs_a = i_a[A_W-1] ? A_W'(-i_a) : A_W'(i_a);
    assign w_abs_b = i_b[B_W-1] ? B_W'(-i_b) : B_W'(i_b);

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (SW'(r_pp[i][j]) << ((i + j) * MUL_CHUNK));
            end
        end
    end

    assign n_p = P_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= AX'(w_abs_a);
            r_mb   <= BX'(w_abs_b);
            r_neg1 <= i_a[A_W-1] ^ i_b[B_W-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= r_ma[i*MUL_CHUNK +: MUL_CHUNK] *
                                  r_mb[j*MUL_CHUNK +: MUL_CHUNK];
                end
            end
            r_neg2 <= r_neg1;
            r_sum  <= n_sum;
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? -n_p : n_p;
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ----- hw/rtl/ssd_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined clamped divider
// Computes clamp(num/den, 0, 1) as a truncated fraction, one quotient bit per
// stage. A divisor or dividend that is not positive gives zero.
// ----------------------------------------------------------------------------
module ssd_div #(
    parameter int W = 8,
    parameter int F = 8
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic [F:0]          o_q
);

    logic [W-1:0] r_n [F+1];
    logic [W-1:0] r_d [F+1];
    logic [F-1:0] r_q [F+1];
    logic [F:0]   r_z;
    logic [F:0]   r_o;
    logic [W-1:0] n_n [1:F];
    logic [F-1:0] n_q [1:F];

    always_comb begin
        logic [W:0] w_sh;
        logic [W:0] w_dx;
        for (int k = 1; k <= F; k++) begin
            w_sh = {r_n[k-1], 1'b0};
            w_dx = {1'b0, r_d[k-1]};
            if (w_sh >= w_dx) begin
                n_n[k] = W'(w_sh - w_dx);
                n_q[k] = F'({r_q[k-1], 1'b1});
            end else begin
                n_n[k] = W'(w_sh);
                n_q[k] = F'({r_q[k-1], 1'b0});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0] <= i_den[W-1] || (i_den == '0) || i_num[W-1] || (i_num == '0);
            r_o[0] <= i_num >= i_den;
            r_n[0] <= i_num;
            r_d[0] <= i_den;
            r_q[0] <= '0;
            for (int k = 1; k <= F; k++) begin
                r_n[k] <= n_n[k];
                r_q[k] <= n_q[k];
                r_d[k] <= r_d[k-1];
                r_z[k] <= r_z[k-1];
                r_o[k] <= r_o[k-1];
            end
        end
    end

    assign o_q = r_z[F] ? '0 : (r_o[F] ? {1'b1, {F{1'b0}}} : {1'b0, r_q[F]});

endmodule
`default_nettype wire

// ----- hw/rtl/ssd_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit by digit floor root, one result bit per stage.
// ----------------------------------------------------------------------------
module ssd_sqrt #(
    parameter int RB = 8
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RB-1:0] i_x,
    output logic [RB-1:0]   o_root
);

    localparam int RMW = RB + 3;

    logic [RMW-1:0]  r_rem  [RB];
    logic [RB-1:0]   r_root [RB];
    logic [2*RB-1:0] r_x    [RB];
    logic [RMW-1:0]  n_rem  [RB];
    logic [RB-1:0]   n_root [RB];
    logic [2*RB-1:0] n_x    [RB];

    always_comb begin
        logic [RMW-1:0]  p_rem;
        logic [RB-1:0]   p_root;
        logic [2*RB-1:0] p_x;
        logic [RMW-1:0]  w_cur;
        logic [RMW-1:0]  w_try;
        for (int j = 0; j < RB; j++) begin
            if (j == 0) begin
                p_rem  = '0;
                p_root = '0;
                p_x    = i_x;
            end else begin
                p_rem  = r_rem[j-1];
                p_root = r_root[j-1];
                p_x    = r_x[j-1];
            end
            w_cur = {p_rem[RMW-3:0], p_x[2*RB-1 -: 2]};
            w_try = RMW'({p_root, 2'b01});
            if (w_cur >= w_try) begin
                n_rem[j]  = w_cur - w_try;
                n_root[j] = RB'({p_root, 1'b1});
            end else begin
                n_rem[j]  = w_cur;
                n_root[j] = RB'({p_root, 1'b0});
            end
            n_x[j] = (2*RB)'({p_x, 2'b00});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < RB; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_x[j]    <= n_x[j];
            end
        end
    end

    assign o_root = r_root[RB-1];

endmodule
`default_nettype wire
